[src/gdb_pkg.sv]
// Shared types, constants and helper functions of the Gregorian day-count block.
package gdb_pkg;

	// Field widths of one input beat and one result beat
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned COUNT_W = 23;
	localparam int unsigned IN_W    = 48;
	localparam int unsigned OUT_W   = 24;

	// Highest year that is taken as it stands
	localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);

	// Day numbers of years up to MAX_YEAR fit in 22 bits; differences in 24 bits
	localparam int unsigned DNUM_W = 22;
	localparam int unsigned DIFF_W = 24;

	// Quotient by 100 as a multiply by 2^19/100 rounded up, exact for 14-bit years
	localparam int unsigned RECIP_W     = 13;
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
	localparam int unsigned RECIP_SHIFT = 19;
	localparam int unsigned CENT_W      = 7;
	localparam int unsigned PROD_W      = YEAR_W + RECIP_W;

	localparam logic [MONTH_W-1:0] MONTH_FIRST = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_LAST  = MONTH_W'(12);

	localparam logic signed [DIFF_W-1:0] COUNT_MAX = DIFF_W'(4194303);
	localparam logic signed [DIFF_W-1:0] COUNT_MIN = -DIFF_W'(4194304);

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVP,
		ST_DIVY,
		ST_WHOLE,
		ST_DAY,
		ST_FINISH
	} state_t;

	// Which date the datapath works on in the current pass
	typedef enum logic {
		SEL_END,
		SEL_START
	} date_sel_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic      load_in;
		logic      do_divp;
		logic      do_divy;
		logic      do_whole;
		logic      do_day;
		logic      load_out;
		date_sel_t sel;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic bad;
	} dp_status_t;

	// A year of zero is taken as 1, any year above MAX_YEAR as MAX_YEAR
	function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y);
		logic [YEAR_W-1:0] r;
		r = y;
		if (y == '0) begin
			r = YEAR_W'(1);
		end else if (y > MAX_YEAR) begin
			r = MAX_YEAR;
		end
		return r;
	endfunction

	function automatic logic month_ok(input logic [MONTH_W-1:0] m);
		return (m >= MONTH_FIRST) && (m <= MONTH_LAST);
	endfunction

	// Days before the first of a month; index is month minus one
	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] idx,
		input logic leap);
		logic [8:0] r;
		case (idx)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = leap ? 9'd60  : 9'd59;
			4'd3:    r = leap ? 9'd91  : 9'd90;
			4'd4:    r = leap ? 9'd121 : 9'd120;
			4'd5:    r = leap ? 9'd152 : 9'd151;
			4'd6:    r = leap ? 9'd182 : 9'd181;
			4'd7:    r = leap ? 9'd213 : 9'd212;
			4'd8:    r = leap ? 9'd244 : 9'd243;
			4'd9:    r = leap ? 9'd274 : 9'd273;
			4'd10:   r = leap ? 9'd305 : 9'd304;
			default: r = leap ? 9'd335 : 9'd334;
		endcase
		return r;
	endfunction

endpackage

[src/gregorian_days_between_dates.sv]
// Top level of the Gregorian day-count block: controller and datapath.
//
//  channel  | dir | handshake                      | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | tdata: both dates
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | tdata: day_count, tuser: bad_date
//
// A valid date pair goes through one capture, four steps per date (DIVP and
// DIVY on the shared divide-by-100 multiplier, then WHOLE and DAY) and one
// load into the output register. A pair with a bad month goes from the
// capture through DIVP straight to the load. A new beat is accepted once the
// previous result sits in the output register, even while that result is
// still stalled. The asynchronous reset clears the controller and the output valid flag.
module gregorian_days_between_dates (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// start_year[13:0], start_month[17:14], start_day[22:18],
	// end_year[36:23], end_month[40:37], end_day[45:41], zero fill [47:46]
	input  logic [gdb_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// day_count[22:0], zero fill [23]
	output logic [gdb_pkg::OUT_W-1:0]   m_axis_tdata,
	// bad_date[0]
	output logic                        m_axis_tuser
);
	import gdb_pkg::*;

	dp_cmd_t            cmd;
	dp_status_t         status;
	logic [COUNT_W-1:0] day_count;

	gdb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	gdb_dp u_dp (
		.clk       (clk),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.status    (status),
		.day_count (day_count),
		.bad_date  (m_axis_tuser)
	);

	assign m_axis_tdata = {1'b0, day_count};

endmodule

[src/gdb_ctrl.sv]
// Controller state machine that sequences the two day-number passes and the result beat.
module gdb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  gdb_pkg::dp_status_t status,
	output gdb_pkg::dp_cmd_t    cmd
);
	import gdb_pkg::*;

	state_t    state_q, state_next;
	date_sel_t sel_q, sel_next;
	logic      out_valid_q;
	logic      out_free;

	// The result register may be refilled once it is empty or being taken
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_next = state_q;
		sel_next   = sel_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_DIVP;
					sel_next   = SEL_END;
				end
			end
			ST_DIVP: begin
				state_next = status.bad ? ST_FINISH : ST_DIVY;
			end
			ST_DIVY:  state_next = ST_WHOLE;
			ST_WHOLE: state_next = ST_DAY;
			ST_DAY: begin
				if (sel_q == SEL_END) begin
					sel_next   = SEL_START;
					state_next = ST_DIVP;
				end else begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Outputs to the datapath and the input handshake
	always_comb begin
		cmd          = '0;
		cmd.sel      = sel_q;
		in_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_DIVP:   cmd.do_divp  = 1'b1;
			ST_DIVY:   cmd.do_divy  = 1'b1;
			ST_WHOLE:  cmd.do_whole = 1'b1;
			ST_DAY:    cmd.do_day   = 1'b1;
			ST_FINISH: cmd.load_out = out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State, pass select and result-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= SEL_END;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			sel_q   <= sel_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/gdb_dp.sv]
// Datapath: captured dates, day-number arithmetic and the result register.
module gdb_dp (
	input  logic                         clk,
	input  logic [gdb_pkg::IN_W-1:0]     in_data,
	input  gdb_pkg::dp_cmd_t             cmd,
	output gdb_pkg::dp_status_t          status,
	output logic [gdb_pkg::COUNT_W-1:0]  day_count,
	output logic                         bad_date
);
	import gdb_pkg::*;

	logic [YEAR_W-1:0]  sy_q, ey_q;
	logic [MONTH_W-1:0] sm_q, em_q;
	logic [DAY_W-1:0]   sd_q, ed_q;

	logic [YEAR_W-1:0]  yr, prev;
	logic [MONTH_W-1:0] mon, mon_idx;
	logic [DAY_W-1:0]   dom;
	logic [PROD_W-1:0]  prod;
	logic [CENT_W-1:0]  qp_q, qy_q;
	logic               leap_q;
	logic [DNUM_W-1:0]  whole_q, end_q, dnum;
	logic signed [DIFF_W-1:0] diff_q, sat;
	logic [COUNT_W-1:0] count_q;
	logic               bad_q;

	// Beat capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sy_q <= in_data[13:0];
			sm_q <= in_data[17:14];
			sd_q <= in_data[22:18];
			ey_q <= in_data[36:23];
			em_q <= in_data[40:37];
			ed_q <= in_data[45:41];
		end
	end

	assign status.bad = !month_ok(sm_q) || !month_ok(em_q);

	// Date of the current pass
	assign yr      = clamp_year((cmd.sel == SEL_START) ? sy_q : ey_q);
	assign mon     = (cmd.sel == SEL_START) ? sm_q : em_q;
	assign dom     = (cmd.sel == SEL_START) ? sd_q : ed_q;
	assign prev    = yr - YEAR_W'(1);
	assign mon_idx = mon - MONTH_W'(1);

	// One shared multiplier gives the quotient by 100 of the previous year, then of the year
	assign prod = PROD_W'(cmd.do_divy ? yr : prev) * PROD_W'(RECIP_100);

	always_ff @(posedge clk) begin
		if (cmd.do_divp) begin
			qp_q <= CENT_W'(prod >> RECIP_SHIFT);
		end
		if (cmd.do_divy) begin
			qy_q <= CENT_W'(prod >> RECIP_SHIFT);
		end
	end

	// Days in whole years before this one, and the leap test of this year
	always_ff @(posedge clk) begin
		if (cmd.do_whole) begin
			whole_q <= DNUM_W'(prev) * DNUM_W'(365) + DNUM_W'(prev >> 2)
				- DNUM_W'(qp_q) + DNUM_W'(qp_q >> 2);
			leap_q  <= (yr[1:0] == 2'b00)
				&& ((YEAR_W'(qy_q) * YEAR_W'(100) != yr) || (qy_q[1:0] == 2'b00));
		end
	end

	// Day number of the date; the day is added as it stands
	assign dnum = whole_q + DNUM_W'(days_before(mon_idx, leap_q)) + DNUM_W'(dom);

	always_ff @(posedge clk) begin
		if (cmd.do_day) begin
			if (cmd.sel == SEL_END) begin
				end_q <= dnum;
			end else begin
				diff_q <= $signed({2'b00, end_q}) - $signed({2'b00, dnum});
			end
		end
	end

	// Saturate to the signed count range
	always_comb begin
		sat = diff_q;
		if (diff_q > COUNT_MAX) begin
			sat = COUNT_MAX;
		end else if (diff_q < COUNT_MIN) begin
			sat = COUNT_MIN;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			bad_q   <= status.bad;
			count_q <= status.bad ? '0 : COUNT_W'(sat);
		end
	end

	assign day_count = count_q;
	assign bad_date  = bad_q;

endmodule

[src/gdb_checker.sv]
// Port-level checker of the Gregorian day-count block and its bind.
module gdb_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [gdb_pkg::OUT_W-1:0] m_axis_tdata,
	input logic                      m_axis_tuser
);
	import gdb_pkg::*;

	// A stalled result beat stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result payload changed while stalled");

	// A bad month gives a count of zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("bad date with non-zero count");

	// One date pair at a time: the block is busy after it takes a beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a pair is in work");

	// A new result follows a busy cycle
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without work");

endmodule

bind gregorian_days_between_dates gdb_checker u_gdb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

[tb/tb_gregorian_days_between_dates.sv]
// Self-checking testbench for the Gregorian day-count block, with its own span predictor.
`timescale 1ns / 100ps

module tb_gregorian_days_between_dates;
	import gdb_pkg::*;

	localparam int CLK_PERIOD    = 20;
	localparam int RESET_CYCLES  = 11;
	localparam int RANDOM_PAIRS  = 1750;
	localparam int DRAIN_AT      = 875;
	localparam int HOLD_AFTER    = 300;
	localparam int HOLD_CYCLES   = 400;
	localparam int TAIL_CYCLES   = 40;
	localparam int WATCHDOG_IDLE = 4000;

	localparam longint SPAN_TOP    = 4194303;
	localparam longint SPAN_BOTTOM = -4194304;

	// Cumulative days before each month of a common year
	localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	// One input beat; the last field sits in the lowest bits
	typedef struct packed {
		logic [DAY_W-1:0]   end_day;
		logic [MONTH_W-1:0] end_month;
		logic [YEAR_W-1:0]  end_year;
		logic [DAY_W-1:0]   start_day;
		logic [MONTH_W-1:0] start_month;
		logic [YEAR_W-1:0]  start_year;
	} date_pair_t;

	// One result beat
	typedef struct packed {
		logic signed [COUNT_W-1:0] count;
		logic                      bad;
	} span_t;

	// A directed row, with its result typed in where it is obvious
	typedef struct packed {
		date_pair_t pair;
		logic       typed;
		span_t      want;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_W-1:0]    m_axis_tdata;
	logic                m_axis_tuser;

	span_t span_q [$];
	span_t offered_span;
	int    errors = 0;
	int    pairs_in = 0;
	int    spans_out = 0;
	int    bad_out = 0;
	int    negative_out = 0;
	int    idle_cycles = 0;
	int    burst_left = 0;

	gregorian_days_between_dates u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Days from the start of the calendar up to and including the given date
	function automatic longint date_ordinal(input logic [YEAR_W-1:0] y_in,
		input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d);
		longint y;
		longint p;
		longint days;
		bit     leap;
		y = y_in;
		if (y < 1) begin
			y = 1;
		end else if (y > longint'(MAX_YEAR)) begin
			y = longint'(MAX_YEAR);
		end
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		p = y - 1;
		days = p * 365 + p / 4 - p / 100 + p / 400;
		days += MONTH_START[int'(m) - 1];
		if (leap && m > 2) begin
			days += 1;
		end
		return days + longint'(d);
	endfunction

	// Expected result beat for one date pair
	function automatic span_t predict_span(input date_pair_t dp);
		span_t  r;
		longint diff;
		r.count = '0;
		r.bad   = 1'b0;
		if (dp.start_month == 0 || dp.start_month > 12 ||
			dp.end_month == 0 || dp.end_month > 12) begin
			r.bad = 1'b1;
		end else begin
			diff = date_ordinal(dp.end_year, dp.end_month, dp.end_day)
				- date_ordinal(dp.start_year, dp.start_month, dp.start_day);
			if (diff > SPAN_TOP) begin
				diff = SPAN_TOP;
			end
			if (diff < SPAN_BOTTOM) begin
				diff = SPAN_BOTTOM;
			end
			r.count = COUNT_W'(diff);
		end
		return r;
	endfunction

	function automatic dir_row_t mk_row(input int sy, input int sm, input int sd,
		input int ey, input int em, input int ed, input bit typed, input int cnt,
		input bit bad);
		dir_row_t r;
		r.pair.start_year  = YEAR_W'(sy);
		r.pair.start_month = MONTH_W'(sm);
		r.pair.start_day   = DAY_W'(sd);
		r.pair.end_year    = YEAR_W'(ey);
		r.pair.end_month   = MONTH_W'(em);
		r.pair.end_day     = DAY_W'(ed);
		r.typed      = typed;
		r.want.count = COUNT_W'(cnt);
		r.want.bad   = bad;
		return r;
	endfunction

	// A month is mostly valid, now and then any 4-bit value
	function automatic logic [MONTH_W-1:0] random_month();
		if ($urandom_range(0, 9) == 0) begin
			return MONTH_W'($urandom_range(0, 15));
		end
		return MONTH_W'($urandom_range(1, 12));
	endfunction

	// Random date pair: half the spans are short, the rest anywhere in the calendar
	function automatic date_pair_t random_pair();
		date_pair_t dp;
		int         sy;
		int         ey;
		int         pick;
		if ($urandom_range(0, 9) == 0) begin
			sy = $urandom_range(0, 16383);
		end else begin
			sy = $urandom_range(1, 9999);
		end
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			ey = sy + $urandom_range(0, 300) - 150;
			if (ey < 0) begin
				ey = 0;
			end
			if (ey > 16383) begin
				ey = 16383;
			end
		end else if (pick < 85) begin
			ey = $urandom_range(1, 9999);
		end else begin
			ey = $urandom_range(0, 16383);
		end
		dp.start_year  = YEAR_W'(sy);
		dp.start_month = random_month();
		dp.start_day   = DAY_W'($urandom_range(0, 31));
		dp.end_year    = YEAR_W'(ey);
		dp.end_month   = random_month();
		dp.end_day     = DAY_W'($urandom_range(0, 31));
		return dp;
	endfunction

	// Offer one beat in bursts with random gaps; returns at the falling edge after acceptance
	task automatic send_pair(input date_pair_t dp, input span_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tdata  <= {{(IN_W - $bits(date_pair_t)){1'b0}}, dp};
		s_axis_tvalid <= 1'b1;
		offered_span  <= want;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Result check first, then record the beat accepted at the same edge
	always @(posedge clk) begin
		span_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				spans_out++;
				if (m_axis_tuser) begin
					bad_out++;
				end
				if (m_axis_tdata[COUNT_W-1] && !m_axis_tuser) begin
					negative_out++;
				end
				if (span_q.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected: count %0d bad %0b", $time,
						$signed(m_axis_tdata[COUNT_W-1:0]), m_axis_tuser);
				end else begin
					want = span_q.pop_front();
					if (m_axis_tdata !== {{(OUT_W - COUNT_W){1'b0}}, want.count}) begin
						errors++;
						$display("%0t: day_count mismatch: expected %0d (0x%h), actual %0d (0x%h)",
							$time, want.count, want.count,
							$signed(m_axis_tdata[COUNT_W-1:0]), m_axis_tdata);
					end
					if (m_axis_tuser !== want.bad) begin
						errors++;
						$display("%0t: bad_date mismatch: expected %0b, actual %0b", $time,
							want.bad, m_axis_tuser);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				span_q.push_back(offered_span);
				pairs_in++;
			end
		end
	end

	// Watchdog: too long without any beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_IDLE) begin
				$display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
					idle_cycles, span_q.size());
				$display("TEST FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Receiver: rotates through stall patterns, with one long hold-off
	initial begin
		int  rx_cycle;
		int  k;
		bit  hold_done;
		rx_cycle  = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (!hold_done && pairs_in >= HOLD_AFTER) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++) begin
					@(negedge clk);
				end
			end else begin
				case ((rx_cycle / 64) % 4)
					0: begin
						m_axis_tready <= 1'b1;
					end
					1: begin
						m_axis_tready <= ($urandom_range(0, 1) == 1);
					end
					2: begin
						m_axis_tready <= ($urandom_range(0, 5) == 0);
					end
					default: begin
						m_axis_tready <= rx_cycle[2];
					end
				endcase
			end
		end
	end

	// Stimulus: reset, directed rows, then random pairs with one full drain mid-run
	initial begin
		dir_row_t   dir_rows [$];
		date_pair_t dp;
		int         i;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Same date, calendar extremes and clamped years
		dir_rows.push_back(mk_row(2024, 6, 15, 2024, 6, 15, 1, 0, 0));
		dir_rows.push_back(mk_row(1, 1, 1, 9999, 12, 31, 1, 3652058, 0));
		dir_rows.push_back(mk_row(9999, 12, 31, 1, 1, 1, 1, -3652058, 0));
		dir_rows.push_back(mk_row(0, 1, 1, 1, 1, 1, 1, 0, 0));
		dir_rows.push_back(mk_row(16383, 12, 31, 9999, 12, 31, 1, 0, 0));
		// Months out of range on either side
		dir_rows.push_back(mk_row(2000, 0, 1, 2000, 1, 1, 1, 0, 1));
		dir_rows.push_back(mk_row(2000, 1, 1, 2000, 13, 1, 1, 0, 1));
		dir_rows.push_back(mk_row(16383, 15, 31, 0, 15, 31, 1, 0, 1));
		dir_rows.push_back(mk_row(0, 0, 0, 16383, 14, 0, 1, 0, 1));
		// Year boundaries and the leap rule
		dir_rows.push_back(mk_row(1999, 12, 31, 2000, 1, 1, 1, 1, 0));
		dir_rows.push_back(mk_row(2000, 2, 28, 2000, 3, 1, 1, 2, 0));
		dir_rows.push_back(mk_row(1900, 2, 28, 1900, 3, 1, 1, 1, 0));
		dir_rows.push_back(mk_row(2024, 2, 29, 2024, 3, 1, 1, 1, 0));
		dir_rows.push_back(mk_row(2023, 12, 31, 2024, 12, 31, 1, 366, 0));
		dir_rows.push_back(mk_row(2023, 12, 31, 2023, 1, 1, 1, -364, 0));
		// Day zero and days past the end of the month
		dir_rows.push_back(mk_row(2023, 3, 0, 2023, 2, 28, 1, 0, 0));
		dir_rows.push_back(mk_row(2023, 2, 31, 2023, 3, 3, 1, 0, 0));
		dir_rows.push_back(mk_row(2023, 1, 0, 2022, 12, 31, 1, 0, 0));
		dir_rows.push_back(mk_row(1, 1, 0, 1, 1, 1, 1, 1, 0));
		// Left to the predictor
		dir_rows.push_back(mk_row(1, 1, 1, 1, 12, 31, 0, 0, 0));
		dir_rows.push_back(mk_row(1600, 2, 29, 2100, 3, 1, 0, 0, 0));
		dir_rows.push_back(mk_row(5000, 7, 4, 1234, 11, 19, 0, 0, 0));
		dir_rows.push_back(mk_row(0, 12, 31, 0, 1, 1, 0, 0, 0));
		dir_rows.push_back(mk_row(8191, 8, 16, 4096, 4, 31, 0, 0, 0));

		foreach (dir_rows[j]) begin
			send_pair(dir_rows[j].pair,
				dir_rows[j].typed ? dir_rows[j].want : predict_span(dir_rows[j].pair));
		end

		for (i = 0; i < RANDOM_PAIRS; i++) begin
			if (i == DRAIN_AT) begin
				// Hold the input until every outstanding result has come out
				s_axis_tvalid <= 1'b0;
				while (span_q.size() != 0) begin
					@(negedge clk);
				end
				@(negedge clk);
				burst_left = 0;
			end
			dp = random_pair();
			send_pair(dp, predict_span(dp));
		end

		// Drain, then watch for stray results
		s_axis_tvalid <= 1'b0;
		while (span_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(negedge clk);
		if (span_q.size() != 0) begin
			errors++;
		end

		$display("Run covered %0d date pairs and %0d results: %0d with a bad month, %0d negative.",
			pairs_in, spans_out, bad_out, negative_out);
		$display("It included one long output stall with input back-pressure and a full drain.");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d errors", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
